FILE: hdl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon locator package
// Sizes, field positions, action codes and shared types of the locator.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int MAX_POLYGONS = 64;
   localparam int MAX_VERTICES = 8;
   localparam int COORD_BITS   = 32;
   localparam int MIN_VERTICES = 3;

   localparam int POLY_W  = $clog2(MAX_POLYGONS);
   localparam int VERT_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int VADDR_W = POLY_W + VERT_W;
   localparam int ENTRY_W = 2 * COORD_BITS;
   localparam int PROD_W  = 2 * COORD_BITS;
   localparam int CFG_W   = 7;

   // Input transaction field widths and positions in req_tdata.
   localparam int ACTION_W   = 3;
   localparam int F_PIDX_W   = 6;
   localparam int F_VIDX_W   = 3;
   localparam int F_VCNT_W   = 4;
   localparam int F_COORD_W  = 32;
   localparam int F_PIDX_LO  = 0;
   localparam int F_VIDX_LO  = F_PIDX_LO + F_PIDX_W;
   localparam int F_VCNT_LO  = F_VIDX_LO + F_VIDX_W;
   localparam int F_X_LO     = F_VCNT_LO + F_VCNT_W;
   localparam int F_Z_LO     = F_X_LO + F_COORD_W;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;

   localparam logic [ACTION_W-1:0] ACT_WRITE_VERTEX = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SET_COUNT    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BLOCK        = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_UNBLOCK      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LOCATE       = 3'd4;

   typedef struct packed {
      logic              cnt_we;
      logic              blk_we;
      logic [POLY_W-1:0] addr;
      logic [CNT_W-1:0]  cnt;
      logic              blk;
   } tbl_wr_type;

   typedef struct packed {
      logic data_valid;  // vertex read data is present this cycle
      logic is_edge;     // the data closes an edge with the previous vertex
      logic clear;       // start of a new polygon
   } edge_ctl_type;

   typedef struct packed {
      logic busy;
      logic in_poly;
   } edge_sts_type;

   // Magnitude of a difference of two coordinates; it always fits COORD_BITS.
   function automatic logic [COORD_BITS-1:0] mag_of(input logic [COORD_BITS:0] v);
      logic [COORD_BITS:0] n;
      n = -v;
      return v[COORD_BITS] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
   endfunction

   function automatic logic prod_neg(input logic [COORD_BITS:0] a,
                                     input logic [COORD_BITS:0] b);
      return (a != '0) && (b != '0) && (a[COORD_BITS] ^ b[COORD_BITS]);
   endfunction

endpackage

FILE: hdl/pip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/pip_poly_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon table
// Vertex counts and blocked flags in two memories, with per-entry valid bits
// so that entries read as zero until written after reset.
// ----------------------------------------------------------------------------
module pip_poly_table
   import pip_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  tbl_wr_type        wr,
   input  logic [POLY_W-1:0] raddr,
   output logic [CNT_W-1:0]  cnt,
   output logic              blk
);

   logic [MAX_POLYGONS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [MAX_POLYGONS-1:0] blk_vld_ff, blk_vld_in;
   logic                    rd_cnt_vld_ff, rd_blk_vld_ff;
   logic [CNT_W-1:0]        cnt_raw;
   logic                    blk_raw;

   pip_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POLYGONS)) u_cnt_ram (
      .clock (clock),
      .we    (wr.cnt_we),
      .waddr (wr.addr),
      .wdata (wr.cnt),
      .raddr (raddr),
      .rdata (cnt_raw)
   );

   pip_ram #(.WIDTH(1), .DEPTH(MAX_POLYGONS)) u_blk_ram (
      .clock (clock),
      .we    (wr.blk_we),
      .waddr (wr.addr),
      .wdata (wr.blk),
      .raddr (raddr),
      .rdata (blk_raw)
   );

   always_comb begin
      cnt_vld_in = cnt_vld_ff;
      blk_vld_in = blk_vld_ff;
      if (wr.cnt_we) begin
         cnt_vld_in[wr.addr] = 1'b1;
      end
      if (wr.blk_we) begin
         blk_vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         blk_vld_ff <= '0;
      end else begin
         cnt_vld_ff <= cnt_vld_in;
         blk_vld_ff <= blk_vld_in;
      end
      rd_cnt_vld_ff <= cnt_vld_ff[raddr];
      rd_blk_vld_ff <= blk_vld_ff[raddr];
   end

   assign cnt = rd_cnt_vld_ff ? cnt_raw : '0;
   assign blk = rd_blk_vld_ff & blk_raw;

endmodule

FILE: hdl/pip_edge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge crossing unit
// Three-stage pipeline that takes one polygon edge per cycle and keeps the
// even-odd crossing parity of the query point.
// ----------------------------------------------------------------------------
module pip_edge_unit
   import pip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  edge_ctl_type          ctl,
   input  logic [ENTRY_W-1:0]    rd_data,
   input  logic [COORD_BITS-1:0] qx,
   input  logic [COORD_BITS-1:0] qz,
   output edge_sts_type          sts
);

   logic [ENTRY_W-1:0] prev_ff;

   // Stage A: differences, magnitudes and signs.
   logic                  a_v_ff, a_cross_ff, a_dpos_ff, a_ln_ff, a_rn_ff;
   logic [COORD_BITS-1:0] a_ma1_ff, a_mb1_ff, a_ma2_ff, a_mb2_ff;
   // Stage M: products.
   logic                  m_v_ff, m_cross_ff, m_dpos_ff, m_ln_ff, m_rn_ff;
   logic [PROD_W-1:0]     m_lm_ff, m_rm_ff;
   logic                  inside_ff, inside_in;

   logic signed [COORD_BITS-1:0] xi, zi, xj, zj, px, pz;
   logic [COORD_BITS:0]          a1, d, a2, b2;
   logic                         cross_in, dpos_in;
   logic                         lt, gt, toggle;

   assign xi = rd_data[COORD_BITS-1:0];
   assign zi = rd_data[ENTRY_W-1:COORD_BITS];
   assign xj = prev_ff[COORD_BITS-1:0];
   assign zj = prev_ff[ENTRY_W-1:COORD_BITS];
   assign px = qx;
   assign pz = qz;

   assign a1 = {px[COORD_BITS-1], px} - {xi[COORD_BITS-1], xi};
   assign d  = {zj[COORD_BITS-1], zj} - {zi[COORD_BITS-1], zi};
   assign a2 = {xj[COORD_BITS-1], xj} - {xi[COORD_BITS-1], xi};
   assign b2 = {pz[COORD_BITS-1], pz} - {zi[COORD_BITS-1], zi};

   assign cross_in = (zi > pz) != (zj > pz);
   assign dpos_in  = !d[COORD_BITS] && (d != '0);

   always_ff @(posedge clock) begin
      if (ctl.data_valid) begin
         prev_ff <= rd_data;
      end
      a_cross_ff <= cross_in;
      a_dpos_ff  <= dpos_in;
      a_ln_ff    <= prod_neg(a1, d);
      a_rn_ff    <= prod_neg(a2, b2);
      a_ma1_ff   <= mag_of(a1);
      a_mb1_ff   <= mag_of(d);
      a_ma2_ff   <= mag_of(a2);
      a_mb2_ff   <= mag_of(b2);
      m_cross_ff <= a_cross_ff;
      m_dpos_ff  <= a_dpos_ff;
      m_ln_ff    <= a_ln_ff;
      m_rn_ff    <= a_rn_ff;
      m_lm_ff    <= PROD_W'(a_ma1_ff) * PROD_W'(a_mb1_ff);
      m_rm_ff    <= PROD_W'(a_ma2_ff) * PROD_W'(a_mb2_ff);
   end

   // Sign-magnitude compare of the two cross products.
   always_comb begin
      if (m_ln_ff != m_rn_ff) begin
         lt = m_ln_ff;
         gt = !m_ln_ff;
      end else if (!m_ln_ff) begin
         lt = m_lm_ff < m_rm_ff;
         gt = m_lm_ff > m_rm_ff;
      end else begin
         lt = m_lm_ff > m_rm_ff;
         gt = m_lm_ff < m_rm_ff;
      end
      toggle    = m_v_ff && m_cross_ff && (m_dpos_ff ? lt : gt);
      inside_in = ctl.clear ? 1'b0 : (inside_ff ^ toggle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff    <= 1'b0;
         m_v_ff    <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         a_v_ff    <= ctl.data_valid && ctl.is_edge;
         m_v_ff    <= a_v_ff;
         inside_ff <= inside_in;
      end
   end

   assign sts.busy    = ctl.data_valid | a_v_ff | m_v_ff;
   assign sts.in_poly = inside_ff;

endmodule

FILE: hdl/point_in_polygon_region_locator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon region locator
// Polygon table with an even-odd crossing search for the first unblocked
// polygon that contains a query point.
// ----------------------------------------------------------------------------
// A vertex write, vertex count, block or unblock transaction is taken without
// a response. A locate transaction walks the first polygons_in_use polygons
// in index order: a blocked polygon or one with fewer than three vertices
// only passes the count read and count check states, any other then reads
// its vertices in the edge state and waits in the drain state for the edge
// unit, and the walk stops at the first polygon that contains the point. The
// vertex memory has a single read port and is read one vertex per cycle. One
// response transaction follows each locate; the block takes the next request
// while the response still waits in its register.
// ----------------------------------------------------------------------------
module point_in_polygon_region_locator_top
   import pip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // poly_index, vertex_index, vertex_count, coord_x, coord_z, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [ACTION_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // region_index, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // found
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CNT_RD  = 6'b000010,
      ST_CNT_CHK = 6'b000100,
      ST_EDGE    = 6'b001000,
      ST_DRAIN   = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      piu_ff;
   logic [CFG_W-1:0]      p_ff, p_in, n_ff, n_in, p_next;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, vi_ff, vi_in, cnt_m1;
   logic [COORD_BITS-1:0] qx_ff, qx_in, qz_ff, qz_in;
   logic                  found_ff, found_in;
   logic [POLY_W-1:0]     region_ff, region_in;
   logic                  rd_v_ff, rd_edge_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [POLY_W-1:0]     rsp_region_ff, rsp_region_in;

   logic                  accept;
   logic [F_PIDX_W-1:0]   f_pidx;
   logic [F_VIDX_W-1:0]   f_vidx;
   logic [F_VCNT_W-1:0]   f_vcnt;
   logic [F_COORD_W-1:0]  f_x, f_z;

   logic                  issue, issue_edge, clear;
   logic [VADDR_W-1:0]    vaddr;
   logic                  vram_we;
   logic [ENTRY_W-1:0]    vram_rdata;
   tbl_wr_type            tbl_wr;
   logic [CNT_W-1:0]      tbl_cnt;
   logic                  tbl_blk;
   edge_ctl_type          ectl;
   edge_sts_type          ests;

   assign f_pidx = req_tdata[F_PIDX_LO +: F_PIDX_W];
   assign f_vidx = req_tdata[F_VIDX_LO +: F_VIDX_W];
   assign f_vcnt = req_tdata[F_VCNT_LO +: F_VCNT_W];
   assign f_x    = req_tdata[F_X_LO +: F_COORD_W];
   assign f_z    = req_tdata[F_Z_LO +: F_COORD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Table and vertex memory writes are only taken at request acceptance.
   always_comb begin
      tbl_wr.cnt_we = 1'b0;
      tbl_wr.blk_we = 1'b0;
      tbl_wr.addr   = f_pidx[POLY_W-1:0];
      tbl_wr.cnt    = (f_vcnt > F_VCNT_W'(MAX_VERTICES)) ?
                      CNT_W'(MAX_VERTICES) : CNT_W'(f_vcnt);
      tbl_wr.blk    = 1'b0;
      vram_we       = 1'b0;
      if (accept) begin
         case (req_tuser)
            ACT_WRITE_VERTEX: vram_we = 1'b1;
            ACT_SET_COUNT:    tbl_wr.cnt_we = 1'b1;
            ACT_BLOCK: begin
               tbl_wr.blk_we = (CFG_W'(f_pidx) < piu_ff);
               tbl_wr.blk    = 1'b1;
            end
            ACT_UNBLOCK:      tbl_wr.blk_we = 1'b1;
            default:          ;
         endcase
      end
   end

   assign p_next = p_ff + CFG_W'(1);
   assign cnt_m1 = tbl_cnt - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      vi_in         = vi_ff;
      qx_in         = qx_ff;
      qz_in         = qz_ff;
      found_in      = found_ff;
      region_in     = region_ff;
      issue         = 1'b0;
      issue_edge    = 1'b0;
      clear         = 1'b0;
      vaddr         = {p_ff[POLY_W-1:0], vi_ff[VERT_W-1:0]};
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_region_in = rsp_region_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == ACT_LOCATE) begin
               qx_in     = f_x[COORD_BITS-1:0];
               qz_in     = f_z[COORD_BITS-1:0];
               p_in      = '0;
               n_in      = (piu_ff > CFG_W'(MAX_POLYGONS)) ? CFG_W'(MAX_POLYGONS) : piu_ff;
               found_in  = 1'b0;
               region_in = '0;
               state_in  = (n_in == '0) ? ST_DONE : ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            if (tbl_blk || tbl_cnt < CNT_W'(MIN_VERTICES)) begin
               p_in     = p_next;
               state_in = (p_next == n_ff) ? ST_DONE : ST_CNT_RD;
            end else begin
               // Load the last vertex first so that edge zero closes the ring.
               cnt_in   = tbl_cnt;
               vi_in    = '0;
               vaddr    = {p_ff[POLY_W-1:0], cnt_m1[VERT_W-1:0]};
               issue    = 1'b1;
               clear    = 1'b1;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (vi_ff != cnt_ff) begin
               issue      = 1'b1;
               issue_edge = 1'b1;
               vi_in      = vi_ff + CNT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!ests.busy) begin
               if (ests.in_poly) begin
                  found_in  = 1'b1;
                  region_in = p_ff[POLY_W-1:0];
                  state_in  = ST_DONE;
               end else begin
                  p_in     = p_next;
                  state_in = (p_next == n_ff) ? ST_DONE : ST_CNT_RD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_region_in = region_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         piu_ff       <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            piu_ff <= csr_wdata;
         end
      end
      p_ff          <= p_in;
      n_ff          <= n_in;
      cnt_ff        <= cnt_in;
      vi_ff         <= vi_in;
      qx_ff         <= qx_in;
      qz_ff         <= qz_in;
      found_ff      <= found_in;
      region_ff     <= region_in;
      rd_edge_ff    <= issue_edge;
      rsp_found_ff  <= rsp_found_in;
      rsp_region_ff <= rsp_region_in;
   end

   pip_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POLYGONS * MAX_VERTICES)) u_vertex_ram (
      .clock (clock),
      .we    (vram_we),
      .waddr ({f_pidx[POLY_W-1:0], f_vidx[VERT_W-1:0]}),
      .wdata ({f_z[COORD_BITS-1:0], f_x[COORD_BITS-1:0]}),
      .raddr (vaddr),
      .rdata (vram_rdata)
   );

   pip_poly_table u_poly_table (
      .clock (clock),
      .reset (reset),
      .wr    (tbl_wr),
      .raddr (p_ff[POLY_W-1:0]),
      .cnt   (tbl_cnt),
      .blk   (tbl_blk)
   );

   assign ectl.data_valid = rd_v_ff;
   assign ectl.is_edge    = rd_edge_ff;
   assign ectl.clear      = clear;

   pip_edge_unit u_edge_unit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ectl),
      .rd_data (vram_rdata),
      .qx      (qx_ff),
      .qz      (qz_ff),
      .sts     (ests)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_region_ff);
   assign rsp_tuser  = rsp_found_ff;

endmodule
